// ===== rtl/core/vpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared sizes for the vertex pair deduplicator.
// ----------------------------------------------------------------------------
`default_nettype none

package vpd_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned INDEX_BITS   = 16;

  // table address and fill count (count can equal MAX_VERTICES)
  localparam int unsigned ADDR_W  = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned KEY_W   = 2 * INDEX_BITS;
  localparam int unsigned CORNER_W = 16;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [CORNER_W-1:0]   corner_t;

  localparam count_t  TABLE_FULL = CNT_W'(MAX_VERTICES);
  localparam corner_t CORNER_MAX = '1;

endpackage

`default_nettype wire

// ===== rtl/core/vertex_pair_deduplicator.sv =====
// ----------------------------------------------------------------------------
// vertex_pair_deduplicator
// Maps (position, normal) index pairs of face corners to unique vertex
// numbers by a linear search of the pairs seen since the last mesh start.
// ----------------------------------------------------------------------------
// A corner is taken when start is high and busy is low. The table of stored
// pairs lives in a single-port RAM that is read one entry per cycle in
// insertion order; the comparator checks one entry per cycle behind the read.
// A hit ends the search at the matching entry. A miss walks all N stored
// entries, at most MAX_VERTICES. The result is shown for one cycle with
// done_o high and must be taken then; the receiver cannot stall. busy is
// low in that cycle, so the next corner may be issued together with it.
// busy stays high for the whole search, so no new corner is taken before
// the result of the last one is shown.
// start_of_mesh clears the table (by its fill count) and sets the corner
// count to one before the search.
`default_nettype none

module vertex_pair_deduplicator
  import vpd_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  output logic                  busy,
  input  wire  [INDEX_BITS-1:0] position_index_i,
  input  wire  [INDEX_BITS-1:0] normal_index_i,
  input  wire                   start_of_mesh_i,
  output logic                  done_o,
  output logic [ADDR_W-1:0]     vertex_index_o,
  output logic                  is_new_o,
  output logic [INDEX_BITS-1:0] fetch_position_o,
  output logic [INDEX_BITS-1:0] fetch_normal_o,
  output logic                  overflow_o,
  output logic [CORNER_W-1:0]   index_count_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  state_e  state_q, state_d;
  key_t    key_q, key_d;
  count_t  cnt_q, cnt_d;       // valid entries in the table
  count_t  rd_idx_q, rd_idx_d; // next entry to read
  addr_t   cmp_idx_q, cmp_idx_d;
  logic    cmp_vld_q, cmp_vld_d;
  corner_t corner_q, corner_d;

  logic    done_d;
  addr_t   vidx_d;
  logic    is_new_d, ovf_d;

  key_t    mem [MAX_VERTICES];
  key_t    rdata_q;
  logic    rd_en, wr_en;
  logic    hit, last;
  logic    accept;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign hit    = cmp_vld_q && (rdata_q == key_q);
  assign last   = (rd_idx_q == cnt_q);
  assign rd_en  = (state_q == ST_SEARCH) && !hit && !last;
  assign wr_en  = (state_q == ST_SEARCH) && !hit && last && (cnt_q != TABLE_FULL);

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = 1'b0;
    corner_d  = corner_q;
    done_d    = 1'b0;
    vidx_d    = vertex_index_o;
    is_new_d  = is_new_o;
    ovf_d     = overflow_o;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d    = {position_index_i - 1'b1, normal_index_i - 1'b1};
          rd_idx_d = '0;
          state_d  = ST_SEARCH;
          if (start_of_mesh_i) begin
            cnt_d    = '0;
            corner_d = CORNER_W'(1);
          end else if (corner_q != CORNER_MAX) begin
            corner_d = corner_q + 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          done_d   = 1'b1;
          vidx_d   = cmp_idx_q;
          is_new_d = 1'b0;
          ovf_d    = 1'b0;
          state_d  = ST_IDLE;
        end else if (last) begin
          // every stored entry compared without a match
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (cnt_q != TABLE_FULL) begin
            vidx_d   = cnt_q[ADDR_W-1:0];
            is_new_d = 1'b1;
            ovf_d    = 1'b0;
            cnt_d    = cnt_q + 1'b1;
          end else begin
            vidx_d   = '0;
            is_new_d = 1'b0;
            ovf_d    = 1'b1;
          end
        end else begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[ADDR_W-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      cnt_q            <= '0;
      rd_idx_q         <= '0;
      cmp_idx_q        <= '0;
      cmp_vld_q        <= 1'b0;
      corner_q         <= '0;
      key_q            <= '0;
      done_o           <= 1'b0;
      vertex_index_o   <= '0;
      is_new_o         <= 1'b0;
      overflow_o       <= 1'b0;
    end else begin
      state_q          <= state_d;
      cnt_q            <= cnt_d;
      rd_idx_q         <= rd_idx_d;
      cmp_idx_q        <= cmp_idx_d;
      cmp_vld_q        <= cmp_vld_d;
      corner_q         <= corner_d;
      key_q            <= key_d;
      done_o           <= done_d;
      vertex_index_o   <= vidx_d;
      is_new_o         <= is_new_d;
      overflow_o       <= ovf_d;
    end
  end

  assign fetch_position_o = key_q[KEY_W-1:INDEX_BITS];
  assign fetch_normal_o   = key_q[INDEX_BITS-1:0];
  assign index_count_o    = corner_q;

  // pair table, one port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[ADDR_W-1:0]] <= key_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_idx_q[ADDR_W-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe outside end of search");

  a_ovf_not_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |-> !is_new_o && (cnt_q == TABLE_FULL))
    else $error("overflow with non-full table or new flag");

  a_new_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_new_o) |-> (cnt_q == count_t'(vertex_index_o) + 1'b1))
    else $error("new vertex number does not match fill count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= TABLE_FULL) && (rd_idx_q <= cnt_q))
    else $error("fill count or read pointer out of range");
`endif

endmodule

`default_nettype wire
